[rtl/sba_pkg.sv]
package sba_pkg;

  // Configuration register widths
  localparam int TF_BITS  = 9;
  localparam int SF_BITS  = 9;
  localparam int OC_BITS  = 13;
  localparam int RW_BITS  = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_FACTOR     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPECTRAL_FACTOR = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_CHANNELS    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_WIDTH       = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_RMW,
    ST_DIV
  } state_t;

endpackage

[rtl/sba_ram.sv]
module sba_ram #(
  parameter int WIDTH     = 40,
  parameter int DEPTH     = 4096,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/sba_div.sv]
module sba_div #(
  parameter int DIVIDEND_BITS = 40,
  parameter int DIVISOR_BITS  = 18,
  parameter int RESULT_BITS   = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [DIVIDEND_BITS-1:0] dividend,
  input  logic        [DIVISOR_BITS-1:0]  divisor,
  output logic                            done,
  output logic signed [RESULT_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);
  localparam logic [DIVIDEND_BITS-1:0] SAT_MAG = DIVIDEND_BITS'(1) << (RESULT_BITS - 1);
  localparam logic signed [RESULT_BITS-1:0] RES_MAX = {1'b0, {(RESULT_BITS-1){1'b1}}};
  localparam logic signed [RESULT_BITS-1:0] RES_MIN = {1'b1, {(RESULT_BITS-1){1'b0}}};

  logic                     running;
  logic [CNT_BITS-1:0]      cnt;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic                     neg;

  logic [DIVISOR_BITS:0]    rem_sh;
  logic [DIVISOR_BITS:0]    rem_sub;
  logic                     take;
  logic [DIVIDEND_BITS-1:0] mag;

  always_comb begin
    rem_sh  = {rem, quo[DIVIDEND_BITS-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    take    = rem_sh >= {1'b0, dvs};
    mag     = dividend[DIVIDEND_BITS-1] ? DIVIDEND_BITS'(-dividend) : DIVIDEND_BITS'(dividend);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running && cnt == '0) begin
      running <= 1'b0;
      done    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIVIDEND_BITS-1];
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_BITS'(DIVIDEND_BITS);
    end else if (running) begin
      if (cnt != '0) begin
        // one quotient bit per cycle, restoring
        rem <= take ? rem_sub[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], take};
        cnt <= cnt - 1'b1;
      end else begin
        // saturate to the sample range and restore the sign
        if (!neg) begin
          quotient <= (quo >= SAT_MAG) ? RES_MAX : RESULT_BITS'(quo);
        end else begin
          quotient <= (quo >= SAT_MAG) ? RES_MIN : RESULT_BITS'(-quo);
        end
      end
    end
  end

endmodule

[rtl/spectrogram_block_average_rebin.sv]
// Block-average rebinner for a row-major spectrogram stream: groups of
// spectral_factor adjacent channels are summed, the group sums are accumulated
// per output column over time_factor rows in an accumulator RAM, and on the
// last row of each block every column emits its total divided by
// time_factor * spectral_factor (truncated toward zero, saturated) with its
// column index and a flag on the last column of the row. A sample is taken
// every cycle, except that after a sample closing a channel group no sample
// is taken during the read-modify-write of the accumulator RAM, and on the
// last row of a block none is taken while the bit-serial divider runs or
// the output register waits to be taken. After reset the accumulator RAM is
// zeroed over all MAX_OUT_CHANNELS addresses, during which no sample is taken;
// configuration writes are taken at any time and must be made while idle.
module spectrogram_block_average_rebin #(
  parameter int MAX_OUT_CHANNELS    = 4096,
  parameter int MAX_TIME_FACTOR     = 256,
  parameter int MAX_SPECTRAL_FACTOR = 256,
  parameter int SAMPLE_BITS         = 24,
  localparam int OCI = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,

  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          sample,

  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          average,
  output logic [OCI-1:0]                         out_column,
  output logic                                   row_done,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sba_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [sba_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  import sba_pkg::*;

  localparam int TFW   = $clog2(MAX_TIME_FACTOR + 1);
  localparam int SFW   = $clog2(MAX_SPECTRAL_FACTOR + 1);
  localparam int CCW   = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int GPW   = (MAX_SPECTRAL_FACTOR > 1) ? $clog2(MAX_SPECTRAL_FACTOR) : 1;
  localparam int RBW   = (MAX_TIME_FACTOR > 1) ? $clog2(MAX_TIME_FACTOR) : 1;
  localparam int GSW   = SAMPLE_BITS + $clog2(MAX_SPECTRAL_FACTOR);
  localparam int CSW   = GSW + $clog2(MAX_TIME_FACTOR);
  localparam int DVW   = TFW + SFW;
  localparam int OCSFW = CCW + SFW;
  localparam int CMPW  = (OCSFW > RW_BITS) ? OCSFW : RW_BITS;

  // configuration
  logic [TF_BITS-1:0] time_factor;
  logic [SF_BITS-1:0] spectral_factor;
  logic [OC_BITS-1:0] out_channels;
  logic [RW_BITS-1:0] row_width;

  logic [TFW-1:0]     tf_eff;
  logic [SFW-1:0]     sf_eff;
  logic [CCW-1:0]     oc_eff;
  logic [RW_BITS-1:0] rw_eff;
  logic [OCSFW-1:0]   ocsf;
  logic [DVW-1:0]     divisor;

  // stream state
  state_t                  state;
  state_t                  state_next;
  logic signed [GSW-1:0]   group_sum;
  logic [RW_BITS-1:0]      channel_count;
  logic [GPW-1:0]          group_position;
  logic [RBW-1:0]          row_in_block;
  logic [CCW-1:0]          column_count;
  logic [OCI-1:0]          clear_addr;

  // group waiting for its accumulator update
  logic signed [GSW-1:0]   pend_sum;
  logic [OCI-1:0]          pend_col;
  logic                    pend_first;
  logic                    pend_last;
  logic                    pend_row_done;

  logic signed [GSW-1:0]   x_ext;
  logic signed [GSW-1:0]   gs_add;
  logic                    active;
  logic [GPW:0]            gp_inc;
  logic                    group_end;
  logic [RW_BITS:0]        ch_inc;
  logic                    row_end;
  logic [RBW:0]            rib_inc;
  logic                    last_row;
  logic                    accept;

  logic                    mem_wr_en;
  logic [OCI-1:0]          mem_wr_addr;
  logic [CSW-1:0]          mem_wr_data;
  logic                    mem_rd_en;
  logic [CSW-1:0]          mem_rd_data;
  logic signed [CSW-1:0]   new_sum;

  logic                    div_start;
  logic                    div_done;
  logic signed [SAMPLE_BITS-1:0] div_quotient;
  logic                    out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_factor     <= TF_BITS'(1);
      spectral_factor <= SF_BITS'(1);
      out_channels    <= OC_BITS'(1);
      row_width       <= RW_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIME_FACTOR:     time_factor     <= cfg_data[TF_BITS-1:0];
        CFG_SPECTRAL_FACTOR: spectral_factor <= cfg_data[SF_BITS-1:0];
        CFG_OUT_CHANNELS:    out_channels    <= cfg_data[OC_BITS-1:0];
        CFG_ROW_WIDTH:       row_width       <= cfg_data[RW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp the registers to their working ranges
  always_comb begin
    if (time_factor == '0) begin
      tf_eff = TFW'(1);
    end else if (32'(time_factor) > MAX_TIME_FACTOR) begin
      tf_eff = TFW'(MAX_TIME_FACTOR);
    end else begin
      tf_eff = TFW'(time_factor);
    end
    if (spectral_factor == '0) begin
      sf_eff = SFW'(1);
    end else if (32'(spectral_factor) > MAX_SPECTRAL_FACTOR) begin
      sf_eff = SFW'(MAX_SPECTRAL_FACTOR);
    end else begin
      sf_eff = SFW'(spectral_factor);
    end
    if (out_channels == '0) begin
      oc_eff = CCW'(1);
    end else if (32'(out_channels) > MAX_OUT_CHANNELS) begin
      oc_eff = CCW'(MAX_OUT_CHANNELS);
    end else begin
      oc_eff = CCW'(out_channels);
    end
    rw_eff  = (row_width == '0) ? RW_BITS'(1) : row_width;
    ocsf    = OCSFW'(oc_eff) * OCSFW'(sf_eff);
    divisor = DVW'(tf_eff) * DVW'(sf_eff);
  end

  always_comb begin
    accept    = in_valid && in_ready;
    x_ext     = GSW'(sample);
    gs_add    = group_sum + x_ext;
    active    = (CMPW'(channel_count) < CMPW'(ocsf)) && (column_count < oc_eff);
    gp_inc    = {1'b0, group_position} + 1'b1;
    group_end = active && (gp_inc >= (GPW + 1)'(sf_eff));
    ch_inc    = {1'b0, channel_count} + 1'b1;
    row_end   = ch_inc >= {1'b0, rw_eff};
    rib_inc   = {1'b0, row_in_block} + 1'b1;
    last_row  = rib_inc >= (RBW + 1)'(tf_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum      <= '0;
      channel_count  <= '0;
      group_position <= '0;
      row_in_block   <= '0;
      column_count   <= '0;
    end else if (accept) begin
      if (row_end || group_end) begin
        group_sum      <= '0;
        group_position <= '0;
      end else if (active) begin
        group_sum      <= gs_add;
        group_position <= gp_inc[GPW-1:0];
      end
      if (row_end) begin
        channel_count <= '0;
        column_count  <= '0;
        row_in_block  <= last_row ? '0 : rib_inc[RBW-1:0];
      end else begin
        channel_count <= ch_inc[RW_BITS-1:0];
        if (group_end) begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

  // capture the closed group for the read-modify-write
  always_ff @(posedge clk) begin
    if (accept && group_end) begin
      pend_sum      <= gs_add;
      pend_col      <= column_count[OCI-1:0];
      pend_first    <= (row_in_block == '0);
      pend_last     <= last_row;
      pend_row_done <= ((column_count + 1'b1) == oc_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == OCI'(MAX_OUT_CHANNELS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_valid && group_end) begin
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        state_next = pend_last ? ST_DIV : ST_RUN;
      end
      ST_DIV: begin
        if (div_done && (!out_valid || out_ready)) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    new_sum     = pend_first ? CSW'(pend_sum) : $signed(mem_rd_data) + CSW'(pend_sum);
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = clear_addr;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      ST_RUN: begin
        in_ready  = 1'b1;
        mem_rd_en = in_valid && group_end;
      end
      ST_RMW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pend_col;
        mem_wr_data = new_sum;
        div_start   = pend_last;
      end
      ST_DIV: begin
        out_load = div_done && (!out_valid || out_ready);
      end
      default: ;
    endcase
  end

  sba_ram #(
    .WIDTH (CSW),
    .DEPTH (MAX_OUT_CHANNELS)
  ) u_column_sums (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (column_count[OCI-1:0]),
    .rd_data (mem_rd_data)
  );

  sba_div #(
    .DIVIDEND_BITS (CSW),
    .DIVISOR_BITS  (DVW),
    .RESULT_BITS   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average    <= div_quotient;
      out_column <= pend_col;
      row_done   <= pend_row_done;
    end
  end

`ifndef SYNTHESIS
  a_group_rmw: assert property (@(posedge clk) disable iff (rst)
    (accept && group_end) |=> (state == ST_RMW && mem_wr_en))
    else $error("closed group not written back in the following cycle");

  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DIV && $past(div_done)))
    else $error("output beat raised without a finished division");

  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done)
    else $error("divider still reports done after a new start");
`endif

endmodule

[bench/sba_average_checker.sv]
module sba_average_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [23:0]                   sample,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [23:0]                   average,
  input  logic [11:0]                          out_column,
  input  logic                                 row_done,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [sba_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sba_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam int unsigned COLS   = 4096;
  localparam int unsigned TF_MAX = 256;
  localparam int unsigned SF_MAX = 256;
  localparam longint AVG_HI = 64'sd8388607;
  localparam longint AVG_LO = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] avg;
    logic [11:0]        col;
    logic               last;
  } average_t;

  average_t average_q[$];

  logic [TF_BITS-1:0] tf_cfg;
  logic [SF_BITS-1:0] sf_cfg;
  logic [OC_BITS-1:0] oc_cfg;
  logic [RW_BITS-1:0] rw_cfg;

  longint      col_total [COLS];
  longint      group_acc;
  int unsigned chan_pos;
  int unsigned grp_pos;
  int unsigned block_row;
  int unsigned col_pos;

  function automatic int unsigned bounded(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void accumulate_sample(logic signed [23:0] x);
    int unsigned tf;
    int unsigned sf;
    int unsigned oc;
    int unsigned rw;
    longint      quot;
    average_t    res;
    tf = bounded(tf_cfg, TF_MAX);
    sf = bounded(sf_cfg, SF_MAX);
    oc = bounded(oc_cfg, COLS);
    rw = (rw_cfg == 0) ? 1 : rw_cfg;
    if (chan_pos < oc * sf && col_pos < oc) begin
      group_acc += x;
      grp_pos++;
      if (grp_pos >= sf) begin
        // first row of a block overwrites whatever the column held
        if (block_row == 0) col_total[col_pos] = group_acc;
        else col_total[col_pos] += group_acc;
        if (block_row + 1 >= tf) begin
          quot = col_total[col_pos] / longint'(tf * sf);
          if (quot > AVG_HI) quot = AVG_HI;
          if (quot < AVG_LO) quot = AVG_LO;
          res.avg  = quot[23:0];
          res.col  = col_pos[11:0];
          res.last = (col_pos + 1 == oc);
          average_q.push_back(res);
        end
        group_acc = 0;
        grp_pos   = 0;
        col_pos++;
      end
    end
    chan_pos++;
    if (chan_pos >= rw) begin
      chan_pos  = 0;
      col_pos   = 0;
      group_acc = 0;
      grp_pos   = 0;
      block_row++;
      if (block_row >= tf) block_row = 0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    average_t want;
    if (rst) begin
      tf_cfg    = 1;
      sf_cfg    = 1;
      oc_cfg    = 1;
      rw_cfg    = 1;
      group_acc = 0;
      chan_pos  = 0;
      grp_pos   = 0;
      block_row = 0;
      col_pos   = 0;
      foreach (col_total[i]) col_total[i] = 0;
      average_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIME_FACTOR:     tf_cfg = cfg_data[TF_BITS-1:0];
          CFG_SPECTRAL_FACTOR: sf_cfg = cfg_data[SF_BITS-1:0];
          CFG_OUT_CHANNELS:    oc_cfg = cfg_data[OC_BITS-1:0];
          CFG_ROW_WIDTH:       rw_cfg = cfg_data[RW_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) accumulate_sample(sample);
      if (out_valid && out_ready) begin
        if (average_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: column %0d average %0d",
                                    out_column, average));
        end else begin
          want = average_q.pop_front();
          if (average !== want.avg)
            report_mismatch($sformatf("column %0d average got %0d expected %0d",
                                      want.col, average, want.avg));
          if (out_column !== want.col)
            report_mismatch($sformatf("out_column got %0d expected %0d", out_column, want.col));
          if (row_done !== want.last)
            report_mismatch($sformatf("column %0d row_done got %0b expected %0b",
                                      want.col, row_done, want.last));
        end
      end
    end
    pending <= average_q.size();
  end

endmodule

[bench/spectrogram_block_average_rebin_test.sv]
module spectrogram_block_average_rebin_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sba_pkg::*;

  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [23:0]  sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [23:0]  average;
  logic [11:0]         out_column;
  logic                row_done;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_TIME_FACTOR;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int sent = 0;

  always #5 clk = ~clk;

  spectrogram_block_average_rebin uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .average(average),
    .out_column(out_column),
    .row_done(row_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  sba_average_checker chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .average(average),
    .out_column(out_column),
    .row_done(row_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  function automatic logic signed [23:0] pick_sample();
    int v;
    v = $urandom_range(16);
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return 24'(v - 8);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic signed [23:0] value);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // bits above each register's width carry junk
  task automatic apply_settings(input int unsigned tf, input int unsigned sf,
                                input int unsigned oc, input int unsigned rw);
    logic [15:0] junk;
    junk = 16'($urandom());
    write_reg(CFG_TIME_FACTOR, {junk[15:9], tf[8:0]});
    write_reg(CFG_SPECTRAL_FACTOR, {junk[15:9], sf[8:0]});
    write_reg(CFG_OUT_CHANNELS, {junk[15:13], oc[12:0]});
    write_reg(CFG_ROW_WIDTH, rw[15:0]);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, drain every expected average, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin
    bit hold_taken;
    int hold_left;
    hold_taken = 1'b0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin
    int unsigned tf;
    int unsigned sf;
    int unsigned oc;
    int unsigned rw;
    int unsigned n;
    int ph;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: each sample is a block of its own
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-24'sd1);
    settle();

    // two rows per block, one spare channel at the end of each row
    apply_settings(2, 1, 2, 3);
    repeat (6) send_sample(pick_sample());
    settle();

    // short row: row ends long before the column range does
    apply_settings(1, 2, 4096, 5);
    repeat (5) send_sample(pick_sample());
    settle();

    // zero registers act as one
    apply_settings(0, 0, 0, 0);
    repeat (2) send_sample(pick_sample());
    settle();

    // carry three rows into a one-row block so the quotient saturates
    apply_settings(4, 1, 1, 1);
    repeat (3) send_sample(SAMPLE_MAX);
    settle();
    apply_settings(1, 1, 1, 1);
    send_sample(SAMPLE_MAX);
    settle();
    apply_settings(4, 1, 1, 1);
    repeat (3) send_sample(SAMPLE_MIN);
    settle();
    apply_settings(1, 1, 1, 1);
    send_sample(SAMPLE_MIN);
    settle();

    // oversized registers clamp; leave the partial state behind
    apply_settings(511, 300, 8191, 65535);
    repeat (3) send_sample(pick_sample());
    settle();

    ph = 0;
    while (sent < 930 || ph < 20) begin
      steady <= (sent >= 400 && sent < 560);
      if (ph == 1) begin
        tf = 1; sf = 1; oc = 8; rw = 8; n = 24;
      end else if (ph % 5 == 4) begin
        case ((ph / 5) % 4)
          0: begin tf = 256; sf = 1; oc = 1; rw = 1; n = 256; end
          1: begin tf = 1; sf = 256; oc = 1; rw = 256; n = 256; end
          2: begin tf = 1; sf = 1; oc = 4096; rw = 24; n = 48; end
          default: begin tf = 1; sf = 2; oc = 3; rw = 65535; n = 16; end
        endcase
      end else begin
        tf = $urandom_range(1, 4);
        sf = $urandom_range(1, 4);
        oc = $urandom_range(1, 6);
        if ($urandom_range(9) == 0) rw = $urandom_range(1, oc * sf);
        else rw = oc * sf + $urandom_range(0, 3);
        n = tf * rw;
        if ($urandom_range(4) == 0) n += $urandom_range(1, rw);
      end
      apply_settings(tf, sf, oc, rw);
      // hold the receiver off while a dense phase streams in
      if (ph == 1) hold_request <= 1'b1;
      repeat (n) send_sample(pick_sample());
      settle();
      ph++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
